// ===== rtl/sorted_table_binary_search_macros.svh =====
// Assertion macros for the sorted table search RTL.
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define STS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted table search: implication check failed");
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted table search: next-cycle check failed");
`else
`define STS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/sts_pkg.sv =====
// Shared constants and controller/datapath interface types for the table search.
`default_nettype none

package sts_pkg;

    // Field widths of the streaming items.
    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;

    // Default number of table entries.
    localparam int TABLE_DEPTH_DEF = 1024;

    // Item kinds carried in s_tuser.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write;   // store the incoming entry in the table
        logic load;    // latch target and range of a new search
        logic probe;   // issue a table read at the midpoint
        logic record;  // remember that the probed entry matched
        logic step;    // narrow the range after a miss
        logic finish;  // move the outcome to the output register
    } sts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;   // the search range holds no entry
        logic hit;     // the probed entry equals the target
    } sts_status_t;

endpackage

`default_nettype wire

// ===== rtl/sts_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sts_ctrl.sv =====
// Controller state machine that sequences table writes and search probes.
`default_nettype none

module sts_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic                s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output sts_pkg::sts_cmd_t        cmd,
    input  wire sts_pkg::sts_status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   in_xfer;

    // New items are taken only between searches; a waiting result does not block.
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    // Next-state and command decode.
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_tuser == sts_pkg::CMD_SEARCH) begin
                        cmd.load   = 1'b1;
                        state_next = ST_PROBE;
                    end else begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_PROBE: begin
                if (status.empty) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.probe  = 1'b1;
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                if (status.hit) begin
                    cmd.record = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = ST_PROBE;
                end
            end
            ST_FINISH: begin
                // Wait until the output register is free or being emptied.
                if (!m_tvalid_reg || m_tready) begin
                    cmd.finish    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sts_datapath.sv =====
// Datapath: value table, search range registers, midpoint and compare logic.
`default_nettype none

module sts_datapath #(
    parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                        aclk,
    input  wire sts_pkg::sts_cmd_t           cmd,
    output sts_pkg::sts_status_t             status,
    input  wire logic [sts_pkg::IDX_W-1:0]   entry_index,
    input  wire logic [sts_pkg::DATA_W-1:0]  data_value,
    input  wire logic [sts_pkg::IDX_W-1:0]   first_index,
    input  wire logic [sts_pkg::IDX_W-1:0]   last_index,
    output logic                             found,
    output logic [sts_pkg::IDX_W-1:0]        match_index
);

    localparam int AW = $clog2(TABLE_DEPTH);
    // Range pointers need room for the table index, one above it and minus one.
    localparam int PW = ((AW > sts_pkg::IDX_W) ? AW : sts_pkg::IDX_W) + 2;
    localparam logic signed [PW-1:0] MAX_IDX = PW'(TABLE_DEPTH - 1);
    localparam logic signed [PW-1:0] ONE     = PW'(1);

    logic signed [PW-1:0]             lo_reg;
    logic signed [PW-1:0]             hi_reg;
    logic signed [PW-1:0]             mid_reg;
    logic signed [PW-1:0]             mid;
    logic signed [PW-1:0]             first_ext;
    logic signed [PW-1:0]             last_ext;
    logic signed [PW-1:0]             entry_ext;
    logic signed [sts_pkg::DATA_W-1:0] target_reg;
    logic signed [sts_pkg::DATA_W-1:0] probe_value;
    logic [sts_pkg::DATA_W-1:0]       rd_data;
    logic                             hit_reg;
    logic                             found_reg;
    logic [sts_pkg::IDX_W-1:0]        match_reg;
    logic                             wr_en;

    // Index fields widened without sign.
    assign first_ext = signed'(PW'(first_index));
    assign last_ext  = signed'(PW'(last_index));
    assign entry_ext = signed'(PW'(entry_index));

    // Writes beyond the table are dropped.
    assign wr_en = cmd.write && (entry_ext <= MAX_IDX);

    // Midpoint of the current range; the difference is non-negative when probed.
    assign mid = lo_reg + ((hi_reg - lo_reg) >>> 1);

    sts_ram #(
        .WIDTH (sts_pkg::DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (entry_ext[AW-1:0]),
        .wr_data (data_value),
        .rd_en   (cmd.probe),
        .rd_addr (mid[AW-1:0]),
        .rd_data (rd_data)
    );

    // Status towards the controller.
    assign probe_value  = signed'(rd_data);
    assign status.empty = (lo_reg > hi_reg);
    assign status.hit   = (probe_value == target_reg);

    // Range, target and midpoint registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            target_reg <= signed'(data_value);
            lo_reg     <= first_ext;
            hi_reg     <= (last_ext > MAX_IDX) ? MAX_IDX : last_ext;
            hit_reg    <= 1'b0;
        end else begin
            if (cmd.probe) begin
                mid_reg <= mid;
            end
            if (cmd.record) begin
                hit_reg <= 1'b1;
            end
            if (cmd.step) begin
                if (target_reg < probe_value) begin
                    hi_reg <= mid_reg - ONE;
                end else begin
                    lo_reg <= mid_reg + ONE;
                end
            end
        end
    end

    // Output register, loaded once per search.
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            found_reg <= hit_reg;
            match_reg <= hit_reg ? mid_reg[sts_pkg::IDX_W-1:0] : '0;
        end
    end

    assign found       = found_reg;
    assign match_index = match_reg;

endmodule

`default_nettype wire

// ===== rtl/sorted_table_binary_search.sv =====
// Search: the item is taken in the idle state, each probe is a registered table read then a
// compare, an empty range is found in the probe state, and the finish state loads the result
// register. A search holds off the input until its result is loaded, longer while an earlier
// result waits on m_tready; the probe loop runs through the single table read port. A write
// is stored as it is accepted, and the block stays ready. aresetn is synchronous, active
// low, and clears the controller and output valid; table contents stay undefined until written.
`default_nettype none

`include "sorted_table_binary_search_macros.svh"

module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: entry_index[9:0], data_value[41:10], first_index[51:42],
    //          last_index[61:52], zero padding[63:62]
    input  wire logic [63:0] s_tdata,
    // s_tuser: cmd[0]
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: found[0], match_index[10:1], zero padding[15:11]
    output logic      [15:0] m_tdata
);

    sts_pkg::sts_cmd_t          cmd;
    sts_pkg::sts_status_t       status;
    logic                       found;
    logic [sts_pkg::IDX_W-1:0]  match_index;

    sts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    sts_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .cmd         (cmd),
        .status      (status),
        .entry_index (s_tdata[9:0]),
        .data_value  (s_tdata[41:10]),
        .first_index (s_tdata[51:42]),
        .last_index  (s_tdata[61:52]),
        .found       (found),
        .match_index (match_index)
    );

    // Result transfer payload.
    assign m_tdata = {5'b0, match_index, found};

    // A table write happens only on an accepted transfer.
    `STS_ASSERT_IMPLY(a_write_on_xfer, aclk, aresetn, cmd.write, s_tvalid && s_tready)
    // A probe is never issued into an empty range.
    `STS_ASSERT_IMPLY(a_probe_nonempty, aclk, aresetn, cmd.probe, !status.empty)
    // The range is never narrowed past a matching entry.
    `STS_ASSERT_IMPLY(a_step_on_miss, aclk, aresetn, cmd.step, !status.hit)
    // Finishing a search always presents a result.
    `STS_ASSERT_NEXT(a_finish_valid, aclk, aresetn, cmd.finish, m_tvalid)

endmodule

`default_nettype wire

// ===== test/sorted_table_binary_search_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the sorted table binary search block.
module sorted_table_binary_search_test;

    localparam int DEPTH         = sts_pkg::TABLE_DEPTH_DEF;
    localparam int IW            = sts_pkg::IDX_W;
    localparam int DW            = sts_pkg::DATA_W;
    localparam int PHASE_ITEMS   = 288;
    localparam int SHADOW_VIEW   = 0;
    localparam int MODEL_VIEW    = 1;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [DW-1:0] MIN_VALUE = 32'h8000_0000;
    localparam logic [DW-1:0] MAX_VALUE = 32'h7FFF_FFFF;

    typedef struct {
        logic          kind;
        logic [IW-1:0] entry;
        logic [DW-1:0] value;
        logic [IW-1:0] first;
        logic [IW-1:0] last;
    } table_op_t;

    typedef struct {
        logic          found;
        logic [IW-1:0] index;
    } lookup_answer_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        s_tuser  = sts_pkg::CMD_WRITE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // Two images of the table: one kept by the stimulus generator as it queues
    // items, one updated as transfers are accepted by the block.
    logic signed [DW-1:0] entry_img [2][DEPTH];
    bit                   shadow_written [DEPTH];

    table_op_t      op_backlog [$];
    table_op_t      next_op;
    lookup_answer_t pending_answers [$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int queued_items       = 0;
    int total_queued       = 0;
    int accepted_items     = 0;
    int writes_seen        = 0;
    int searches_seen      = 0;
    int hits_seen          = 0;
    int error_count        = 0;

    sorted_table_binary_search DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock and a single reset pulse at the start.
    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Hard limit on the run time.
    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Binary search over one table image. The clean flag drops when a probe lands
    // on an entry that the generator has never written.
    function automatic void search_table(input int view, input logic signed [DW-1:0] target,
                                         input int lo_in, input int hi_in, output bit hit,
                                         output logic [IW-1:0] at, output bit clean);
        int lo;
        int hi;
        int mid;
        logic signed [DW-1:0] probe;
        lo    = lo_in;
        hi    = (hi_in > DEPTH - 1) ? DEPTH - 1 : hi_in;
        hit   = 1'b0;
        at    = '0;
        clean = 1'b1;
        while (lo <= hi && !hit) begin
            mid   = lo + (hi - lo) / 2;
            probe = entry_img[view][mid];
            if (!shadow_written[mid]) clean = 1'b0;
            if (target < probe) begin
                hi = mid - 1;
            end else if (probe < target) begin
                lo = mid + 1;
            end else begin
                hit = 1'b1;
                at  = mid[IW-1:0];
            end
        end
    endfunction

    // Values drawn from a narrow band (duplicates), near the extremes, or anywhere.
    function automatic logic [DW-1:0] random_value();
        case ($urandom_range(3))
            0: return $urandom_range(80) - 40;
            1: return $urandom_range(1) ? MIN_VALUE + $urandom_range(3)
                                        : MAX_VALUE - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_write(input int idx, input logic [DW-1:0] val);
        table_op_t op;
        op.kind  = sts_pkg::CMD_WRITE;
        op.entry = idx[IW-1:0];
        op.value = val;
        op.first = IW'($urandom_range(DEPTH - 1));
        op.last  = IW'($urandom_range(DEPTH - 1));
        entry_img[SHADOW_VIEW][idx] = val;
        shadow_written[idx] = 1'b1;
        op_backlog = {op_backlog, op};
        queued_items++;
        total_queued++;
    endtask

    task automatic push_search(input logic [DW-1:0] target, input int lo, input int hi);
        table_op_t op;
        op.kind  = sts_pkg::CMD_SEARCH;
        op.entry = IW'($urandom_range(DEPTH - 1));
        op.value = target;
        op.first = lo[IW-1:0];
        op.last  = hi[IW-1:0];
        op_backlog = {op_backlog, op};
        queued_items++;
        total_queued++;
    endtask

    // A search over an arbitrary range; if its probes would touch an unwritten
    // entry it is replaced by an inverted range, which probes nothing.
    task automatic push_open_search();
        int lo;
        int hi;
        int pos;
        logic [DW-1:0] target;
        bit hit;
        bit clean;
        logic [IW-1:0] at;
        lo     = $urandom_range(DEPTH - 1);
        hi     = $urandom_range(lo, DEPTH - 1);
        pos    = $urandom_range(lo, hi);
        target = random_value();
        if (shadow_written[pos] && $urandom_range(1)) target = entry_img[SHADOW_VIEW][pos];
        search_table(SHADOW_VIEW, target, lo, hi, hit, at, clean);
        if (!clean) begin
            lo = $urandom_range(1, DEPTH - 1);
            hi = $urandom_range(0, lo - 1);
        end
        push_search(target, lo, hi);
    endtask

    // Write an ascending run of entries, then search within it and now and then over an open range.
    task automatic add_sorted_run();
        int len;
        int base;
        int nsearch;
        int lo;
        int hi;
        int pick;
        int k;
        int j;
        logic signed [DW-1:0] vals [200];
        logic signed [DW-1:0] v;
        logic signed [DW-1:0] target;
        len  = ($urandom_range(15) == 0) ? $urandom_range(64, 200) : $urandom_range(1, 24);
        base = $urandom_range(0, DEPTH - len);
        for (k = 0; k < len; k++) begin
            v = random_value();
            j = k;
            while (j > 0 && vals[j-1] > v) begin
                vals[j] = vals[j-1];
                j--;
            end
            vals[j] = v;
        end
        for (k = 0; k < len; k++) push_write(base + k, vals[k]);
        nsearch = $urandom_range(3, 10);
        for (k = 0; k < nsearch; k++) begin
            pick = $urandom_range(9);
            if (pick == 9) begin
                push_open_search();
            end else begin
                lo = base + $urandom_range(0, len - 1);
                hi = $urandom_range(lo, base + len - 1);
                if (pick < 5) begin
                    target = vals[$urandom_range(lo - base, hi - base)];
                end else if (pick < 7) begin
                    target = vals[$urandom_range(lo - base, hi - base)]
                             + ($urandom_range(1) ? 1 : -1);
                end else begin
                    target = random_value();
                end
                push_search(target, lo, hi);
            end
        end
    endtask

    // Input driver: presents queued items, idling at the rate set for the phase.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= sts_pkg::CMD_WRITE;
        end else if (!s_tvalid || s_tready) begin
            if (op_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                next_op = op_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, next_op.last, next_op.first, next_op.value, next_op.entry};
                s_tuser  <= next_op.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: stalls at the rate set for the phase.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Monitor: predicts each accepted transfer and checks each delivered result.
    always @(posedge aclk) begin : watch
        logic [IW-1:0]  lo_f;
        logic [IW-1:0]  hi_f;
        logic [DW-1:0]  val;
        logic [IW-1:0]  at;
        bit             hit;
        bit             clean;
        lookup_answer_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                val  = s_tdata[41:10];
                lo_f = s_tdata[51:42];
                hi_f = s_tdata[61:52];
                if (s_tuser == sts_pkg::CMD_WRITE) begin
                    entry_img[MODEL_VIEW][s_tdata[9:0]] = val;
                    writes_seen++;
                end else begin
                    search_table(MODEL_VIEW, val, int'(lo_f), int'(hi_f), hit, at, clean);
                    want.found = hit;
                    want.index = at;
                    pending_answers = {pending_answers, want};
                    searches_seen++;
                end
                accepted_items++;
            end
            if (m_tvalid && m_tready) begin
                if (pending_answers.size() == 0) begin
                    report_mismatch($sformatf("result 0x%h with no search outstanding", m_tdata));
                end else begin
                    want = pending_answers.pop_front();
                    if (m_tdata[0] !== want.found)
                        report_mismatch($sformatf("found flag %b, predicted %b",
                                                  m_tdata[0], want.found));
                    if (m_tdata[10:1] !== want.index)
                        report_mismatch($sformatf("match index %0d, predicted %0d",
                                                  m_tdata[10:1], want.index));
                    if (want.found) hits_seen++;
                end
            end
        end
    end

    // Stimulus: directed items first, then random runs over four idling phases.
    initial begin : stimulus
        int phase;
        for (int i = 0; i < DEPTH; i++) begin
            entry_img[SHADOW_VIEW][i] = '0;
            entry_img[MODEL_VIEW][i]  = '0;
            shadow_written[i]         = 1'b0;
        end
        while (aresetn !== 1'b1) @(posedge aclk);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct <= 0;  receiver_stall_pct <= 0;  end
                1: begin sender_idle_pct <= 64; receiver_stall_pct <= 0;  end
                2: begin sender_idle_pct <= 0;  receiver_stall_pct <= 64; end
                default: begin sender_idle_pct <= 12; receiver_stall_pct <= 12; end
            endcase
            queued_items = 0;

            if (phase == 0) begin
                // Ascending run spanning the full signed range.
                push_write(0, MIN_VALUE);
                push_write(1, -65536);
                push_write(2, -1);
                push_write(3, 0);
                push_write(4, 1);
                push_write(5, 4096);
                push_write(6, 32'h7FFF_FFFE);
                push_write(7, MAX_VALUE);
                push_write(1023, MAX_VALUE);
                push_write(1022, -5);
                // Descending entries make an unsorted range.
                push_write(8, 30);
                push_write(9, 20);
                push_write(10, 10);
                push_search(MIN_VALUE, 0, 7);
                push_search(MAX_VALUE, 0, 7);
                push_search(0, 0, 7);
                push_search(2, 0, 7);
                push_search(32'h8000_0001, 0, 7);
                push_search(1, 4, 4);
                push_search(1, 5, 5);
                // Inverted ranges give not found without any probe; top-end and unsorted ranges follow.
                push_search(0, 7, 0);
                push_search(MAX_VALUE, 1023, 0);
                push_search(MAX_VALUE, 1023, 1023);
                push_search(-5, 1022, 1023);
                push_search(10, 8, 10);
            end

            while (queued_items < PHASE_ITEMS) begin
                if ($urandom_range(9) == 0) begin
                    repeat ($urandom_range(1, 4))
                        push_write($urandom_range(DEPTH - 1), random_value());
                    push_open_search();
                end else begin
                    add_sorted_run();
                end
            end

            // Wait until every queued item has been accepted and every search answered.
            while (accepted_items != total_queued || pending_answers.size() != 0)
                @(posedge aclk);
            repeat (SETTLE_CYCLES) @(posedge aclk);
        end

        $display("Run covered %0d table writes and %0d searches (%0d found, %0d not found)",
                 writes_seen, searches_seen, hits_seen, searches_seen - hits_seen);
        $display("across four phases of sender idling and receiver back-pressure.");
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
